// File: hdl/address_region_lookup_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the region lookup block
// Shared helpers for concurrent checks on clk_i with rst_ni as disable.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_LOOKUP_TABLE_UNIT_MACROS_SVH
`define ADDRESS_REGION_LOOKUP_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define ARLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/arlt_pkg.sv
// ----------------------------------------------------------------------------
// arlt_pkg
// Sizes, codes and word types of the region lookup block.
// ----------------------------------------------------------------------------
package arlt_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned ADDR_BITS  = 48;
  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned ID_BITS    = 8;
  // address bits actually kept in the table
  localparam int unsigned AW         = (ADDR_BITS < FIELD_BITS) ? ADDR_BITS : FIELD_BITS;
  localparam int unsigned IDX_BITS   = $clog2(ENTRIES);
  localparam int unsigned CNT_BITS   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } arlt_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_ZERO = 2'd3
  } arlt_status_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [FIELD_BITS-1:0] address;
    logic [ID_BITS-1:0]    region_id;
    logic [FIELD_BITS-1:0] region_length;
  } arlt_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  hit;
    logic [ID_BITS-1:0]    found_id;
    logic [FIELD_BITS-1:0] offset;
  } arlt_out_t;

  // table update from the sequencer
  typedef struct packed {
    logic                wr_en;
    logic                clr_en;
    logic [IDX_BITS-1:0] idx;
    logic [AW-1:0]       base;
    logic [AW-1:0]       len;
    logic [ID_BITS-1:0]  id;
  } arlt_upd_t;

  // table read request
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] idx;
  } arlt_rdreq_t;

  // registered table read data
  typedef struct packed {
    logic               valid;
    logic [AW-1:0]      base;
    logic [AW-1:0]      len;
    logic [ID_BITS-1:0] id;
  } arlt_rd_t;

endpackage

// File: hdl/arlt_table.sv
// ----------------------------------------------------------------------------
// arlt_table
// Region table: valid flops plus base, length and id memory, one read port.
// ----------------------------------------------------------------------------
module arlt_table import arlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arlt_upd_t   upd_i,
  input  arlt_rdreq_t rd_req_i,
  output arlt_rd_t    rd_o
);

  logic [ENTRIES-1:0] valid_q;
  logic [AW-1:0]      base_mem [ENTRIES];
  logic [AW-1:0]      len_mem  [ENTRIES];
  logic [ID_BITS-1:0] id_mem   [ENTRIES];
  arlt_rd_t           rd_q;

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i.wr_en) begin
      valid_q[upd_i.idx] <= 1'b1;
    end else if (upd_i.clr_en) begin
      valid_q[upd_i.idx] <= 1'b0;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (upd_i.wr_en) begin
      base_mem[upd_i.idx] <= upd_i.base;
      len_mem[upd_i.idx]  <= upd_i.len;
      id_mem[upd_i.idx]   <= upd_i.id;
    end
    if (rd_req_i.en) begin
      rd_q.valid <= valid_q[rd_req_i.idx];
      rd_q.base  <= base_mem[rd_req_i.idx];
      rd_q.len   <= len_mem[rd_req_i.idx];
      rd_q.id    <= id_mem[rd_req_i.idx];
    end
  end

  assign rd_o = rd_q;

endmodule

// File: hdl/arlt_seq.sv
// ----------------------------------------------------------------------------
// arlt_seq
// Sequencer: scans the table one entry a cycle through a shared compare
// unit, then forms the offset and the result word.
// ----------------------------------------------------------------------------
module arlt_seq import arlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  arlt_in_t    in_data_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output arlt_out_t   res_o,
  output arlt_rdreq_t rd_req_o,
  input  arlt_rd_t    rd_i,
  output arlt_upd_t   upd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_OFS  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [AW-1:0]      addr;
    logic [ID_BITS-1:0] id;
    logic [AW-1:0]      len;
  } item_t;

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                data_vld_q, data_vld_d;
  logic [IDX_BITS-1:0] data_idx_q, data_idx_d;
  logic                dup_q, dup_d;
  logic [IDX_BITS-1:0] dup_idx_q, dup_idx_d;
  logic                free_q, free_d;
  logic [IDX_BITS-1:0] free_idx_q, free_idx_d;
  logic                best_q, best_d;
  logic [AW-1:0]       best_base_q, best_base_d;
  logic [AW-1:0]       best_len_q, best_len_d;
  logic [ID_BITS-1:0]  best_id_q, best_id_d;
  logic [AW-1:0]       ofs_q, ofs_d;

  // shared compare unit on the entry just read
  logic cmp_eq, cmp_le, cmp_gt;
  assign cmp_eq = (rd_i.base == item_q.addr);
  assign cmp_le = (rd_i.base <= item_q.addr);
  assign cmp_gt = (rd_i.base > best_base_q);

  assign in_ready_o = (state_q == S_IDLE);

  // result word and status
  arlt_status_e status;
  logic         hit;

  always_comb begin
    status = ST_OK;
    unique case (item_q.op)
      OP_ADD: begin
        if (item_q.addr == '0) begin
          status = ST_ZERO;
        end else if (dup_q) begin
          status = ST_DUP;
        end else if (!free_q) begin
          status = ST_FULL;
        end
      end
      default: status = ST_OK;
    endcase
    hit = (item_q.op == OP_FIND) && best_q && (ofs_q < best_len_q);
    res_o.status   = status;
    res_o.hit      = hit;
    res_o.found_id = hit ? best_id_q : '0;
    res_o.offset   = hit ? FIELD_BITS'(ofs_q) : '0;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    data_vld_d  = data_vld_q;
    data_idx_d  = data_idx_q;
    dup_d       = dup_q;
    dup_idx_d   = dup_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_base_d = best_base_q;
    best_len_d  = best_len_q;
    best_id_d   = best_id_q;
    ofs_d       = ofs_q;
    rd_req_o    = '{en: 1'b0, idx: cnt_q[IDX_BITS-1:0]};
    res_valid_o = 1'b0;
    upd_o       = '0;
    upd_o.base  = item_q.addr;
    upd_o.len   = item_q.len;
    upd_o.id    = item_q.id;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d.op   = in_data_i.operation;
          item_d.addr = in_data_i.address[AW-1:0];
          item_d.id   = in_data_i.region_id;
          item_d.len  = in_data_i.region_length[AW-1:0];
          dup_d       = 1'b0;
          free_d      = 1'b0;
          best_d      = 1'b0;
          rd_req_o    = '{en: 1'b1, idx: '0};
          cnt_d       = CNT_BITS'(1);
          data_vld_d  = 1'b1;
          data_idx_d  = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the next read while the previous entry is checked
        data_vld_d = 1'b0;
        if (cnt_q < CNT_BITS'(ENTRIES)) begin
          rd_req_o.en = 1'b1;
          cnt_d       = cnt_q + CNT_BITS'(1);
          data_vld_d  = 1'b1;
          data_idx_d  = cnt_q[IDX_BITS-1:0];
        end
        if (data_vld_q) begin
          if (rd_i.valid && cmp_eq) begin
            dup_d     = 1'b1;
            dup_idx_d = data_idx_q;
          end
          if (!rd_i.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = data_idx_q;
          end
          if (rd_i.valid && cmp_le && (!best_q || cmp_gt)) begin
            best_d      = 1'b1;
            best_base_d = rd_i.base;
            best_len_d  = rd_i.len;
            best_id_d   = rd_i.id;
          end
          if (data_idx_q == IDX_BITS'(ENTRIES - 1)) begin
            state_d = S_OFS;
          end
        end
      end
      S_OFS: begin
        ofs_d   = item_q.addr - best_base_q;
        state_d = S_RESP;
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          // commit the table change with the result
          upd_o.wr_en  = (item_q.op == OP_ADD) && (status == ST_OK);
          upd_o.clr_en = (item_q.op == OP_REMOVE) && (item_q.addr != '0) && dup_q;
          upd_o.idx    = (item_q.op == OP_ADD) ? free_idx_q : dup_idx_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      data_vld_q <= 1'b0;
      dup_q      <= 1'b0;
      free_q     <= 1'b0;
      best_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      data_vld_q <= data_vld_d;
      dup_q      <= dup_d;
      free_q     <= free_d;
      best_q     <= best_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    data_idx_q  <= data_idx_d;
    dup_idx_q   <= dup_idx_d;
    free_idx_q  <= free_idx_d;
    best_base_q <= best_base_d;
    best_len_q  <= best_len_d;
    best_id_q   <= best_id_d;
    ofs_q       <= ofs_d;
  end

endmodule

// File: hdl/address_region_lookup_table_unit.sv
// ----------------------------------------------------------------------------
// address_region_lookup_table_unit: region table with add, remove and find
// The block takes no new word until the current result leaves the sequencer;
// the table scan reads one entry per cycle through the single memory read port.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module address_region_lookup_table_unit import arlt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  arlt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output arlt_out_t out_data_o
);

  arlt_rdreq_t rd_req;
  arlt_rd_t    rd;
  arlt_upd_t   upd;
  logic        res_valid;
  logic        res_ready;
  arlt_out_t   res;
  logic        out_valid_q;
  arlt_out_t   out_q;

  arlt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_req_o    (rd_req),
    .rd_i        (rd),
    .upd_o       (upd)
  );

  arlt_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .rd_req_i (rd_req),
    .rd_o     (rd)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/arlt_checker.sv
// ----------------------------------------------------------------------------
// arlt_checker
// Port-level checks of the region lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`include "address_region_lookup_table_unit_macros.svh"

module arlt_port_checker import arlt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input arlt_out_t out_data_o
);

  // stalled result word holds
  `ARLT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // block is busy right after taking a word
  `ARLT_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready high right after accept")

  // a miss carries no id and no offset
  `ARLT_ASSERT_IMP(a_miss_zero, out_valid_o && !out_data_o.hit, (out_data_o.found_id == '0) && (out_data_o.offset == '0), "miss with nonzero id or offset")

  // a hit always reports ok status
  `ARLT_ASSERT_IMP(a_hit_ok, out_valid_o && out_data_o.hit, out_data_o.status == ST_OK, "hit with non-ok status")

endmodule

bind address_region_lookup_table_unit arlt_port_checker u_arlt_checker (.*);
